>>> src/cbf_pkg.sv
// shared types and constants for the command byte fifo
`timescale 1ns / 1ps

package cbf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam logic [7:0]  LINE_END      = 8'h0d;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_LINE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOCMD    = 3'd3,
    ST_EMPTYCMD = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_LINE,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_in;
  } cbf_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    status_e    status;
    logic       last;
    logic       is_empty;
    logic       is_full;
    logic       command_pending;
  } cbf_out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       is_cr;
  } fe_item_t;

  typedef struct packed {
    logic     valid;
    fe_item_t item;
  } fe_req_t;

endpackage

>>> src/cbf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cbf_fifo.sv
// two-entry word queue
`timescale 1ns / 1ps

module cbf_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

>>> src/cbf_front.sv
// front end: decodes incoming words and queues them for the back end
`timescale 1ns / 1ps

module cbf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbf_pkg::cbf_in_t  word_i,
  output logic              full_o,
  output cbf_pkg::fe_req_t  req_o,
  input  logic              rdy_i
);

  import cbf_pkg::*;

  fe_item_t                 item;
  logic [$bits(fe_item_t)-1:0] q_data;
  logic                     q_empty;

  always_comb begin
    item.data  = word_i.byte_in;
    item.is_cr = (word_i.byte_in == LINE_END);
    case (word_i.cmd)
      CMD_PUT:  item.op = OP_PUT;
      CMD_GET:  item.op = OP_GET;
      CMD_LINE: item.op = OP_LINE;
      default:  item.op = OP_NONE;
    endcase
  end

  cbf_fifo #(
    .WIDTH($bits(fe_item_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item),
    .full_o (full_o),
    .pop_i  (rdy_i),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  assign req_o.valid = ~q_empty;
  assign req_o.item  = fe_item_t'(q_data);

endmodule

>>> src/cbf_back.sv
// back end: ring buffer pointers, byte store and command execution
`timescale 1ns / 1ps

module cbf_back #(
  parameter int unsigned DEPTH = cbf_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbf_pkg::fe_req_t  req_i,
  output logic              rdy_o,
  input  logic              res_rdy_i,
  output logic              res_push_o,
  output cbf_pkg::cbf_out_t res_o
);

  import cbf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GET  = 4'b0010,
    S_DRD  = 4'b0100,
    S_DCHK = 4'b1000
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  state_e           state_q, state_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic             flag_q, flag_d;
  logic             have_q, have_d;
  logic [7:0]       pend_q, pend_d;

  logic [PTR_W-1:0] wp_nx, rp_nx;
  logic             buf_empty, buf_full;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;

  assign wp_nx     = ptr_next(wp_q);
  assign rp_nx     = ptr_next(rp_q);
  assign buf_empty = (wp_q == rp_q);
  assign buf_full  = (wp_nx == rp_q);

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    flag_d     = flag_q;
    have_d     = have_q;
    pend_d     = pend_q;
    rdy_o      = 1'b0;
    res_push_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_o.data_out        = 8'd0;
    res_o.status          = ST_OK;
    res_o.last            = 1'b1;
    res_o.is_empty        = buf_empty;
    res_o.is_full         = buf_full;
    res_o.command_pending = flag_q;

    case (state_q)
      S_IDLE: begin
        rdy_o = res_rdy_i;
        if (req_i.valid && res_rdy_i) begin
          case (req_i.item.op)
            OP_PUT: begin
              res_push_o = 1'b1;
              if (buf_full) begin
                res_o.status = ST_FULL;
              end else begin
                ram_we                = 1'b1;
                wp_d                  = wp_nx;
                flag_d                = flag_q | req_i.item.is_cr;
                res_o.is_empty        = 1'b0;
                res_o.is_full         = (ptr_next(wp_nx) == rp_q);
                res_o.command_pending = flag_d;
              end
            end
            OP_GET: begin
              if (buf_empty) begin
                res_push_o   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                state_d = S_GET;
              end
            end
            OP_LINE: begin
              if (flag_q) begin
                have_d  = 1'b0;
                state_d = S_DRD;
              end else begin
                res_push_o   = 1'b1;
                res_o.status = ST_NOCMD;
              end
            end
            default: begin
              res_push_o   = 1'b1;
              res_o.status = ST_NOCMD;
            end
          endcase
        end
      end
      S_GET: begin
        if (res_rdy_i) begin
          res_push_o     = 1'b1;
          res_o.data_out = ram_rdata;
          res_o.is_empty = (rp_nx == wp_q);
          res_o.is_full  = 1'b0;
          rp_d           = rp_nx;
          state_d        = S_IDLE;
        end
      end
      S_DRD: begin
        if (buf_empty) begin
          if (res_rdy_i) begin
            res_push_o            = 1'b1;
            res_o.data_out        = have_q ? pend_q : 8'd0;
            res_o.status          = have_q ? ST_OK : ST_EMPTYCMD;
            res_o.is_empty        = 1'b1;
            res_o.is_full         = 1'b0;
            res_o.command_pending = 1'b0;
            flag_d                = 1'b0;
            state_d               = S_IDLE;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (res_rdy_i) begin
          rp_d           = rp_nx;
          res_o.is_empty = (rp_nx == wp_q);
          res_o.is_full  = 1'b0;
          if (ram_rdata == LINE_END) begin
            res_push_o            = 1'b1;
            res_o.data_out        = have_q ? pend_q : 8'd0;
            res_o.status          = have_q ? ST_OK : ST_EMPTYCMD;
            res_o.command_pending = 1'b0;
            flag_d                = 1'b0;
            state_d               = S_IDLE;
          end else begin
            res_push_o     = have_q;
            res_o.data_out = pend_q;
            res_o.last     = 1'b0;
            pend_d         = ram_rdata;
            have_d         = 1'b1;
            state_d        = S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      flag_q  <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      flag_q  <= flag_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  cbf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(req_i.item.data),
    .re_i   (ram_re),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

endmodule

>>> src/command_byte_fifo_unit.sv
// top level of the command byte fifo
`timescale 1ns / 1ps

// Byte ring buffer of DEPTH slots holding up to DEPTH-1 bytes, with carriage
// return detection. Words enter a two-entry front queue and are executed by
// the back end one at a time; results leave through a two-entry result
// queue. A put, a get on an empty buffer and a refused get-command end in
// the idle state; a get waits in the get state for the registered read of
// the byte store. A get-command drain takes the word, reads each byte via
// the read and check states up to the terminator, and gives the final word
// there or on an empty buffer. The byte store needs no clearing after reset.

module command_byte_fifo_unit #(
  parameter int unsigned DEPTH = cbf_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  cbf_pkg::cbf_in_t  cmd_word_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output cbf_pkg::cbf_out_t res_word_o
);

  import cbf_pkg::*;

  fe_req_t                     fe_req;
  logic                        fe_rdy;
  logic                        res_push;
  logic                        res_full;
  cbf_out_t                    res_word;
  logic [$bits(cbf_out_t)-1:0] res_data;

  cbf_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .word_i(cmd_word_i),
    .full_o(full),
    .req_o (fe_req),
    .rdy_i (fe_rdy)
  );

  cbf_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fe_req),
    .rdy_o     (fe_rdy),
    .res_rdy_i (~res_full),
    .res_push_o(res_push),
    .res_o     (res_word)
  );

  cbf_fifo #(
    .WIDTH($bits(cbf_out_t))
  ) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_word),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_data),
    .empty_o(empty)
  );

  assign res_word_o = cbf_out_t'(res_data);

  a_no_push_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full
  ) else $error("result pushed into full queue");

  a_empty_falls_on_push : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $fell(empty) |-> $past(res_push)
  ) else $error("result queue filled without a push");

  a_full_status_flag : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (!empty && res_word_o.status == ST_FULL) |-> res_word_o.is_full
  ) else $error("dropped byte reported with buffer not full");

  a_empty_status_flag : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (!empty && res_word_o.status == ST_EMPTY) |-> res_word_o.is_empty
  ) else $error("empty status with bytes left in buffer");

endmodule

>>> tb/command_byte_fifo_unit_test.sv
// self-checking testbench for the command byte fifo top level
`timescale 1ns / 1ps

module command_byte_fifo_unit_test;
  import cbf_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEFAULT;
  localparam logic [1:0]  CMD_NONE   = 2'd3;
  localparam int          N_DIRECTED = 23;
  localparam int          N_RANDOM   = 500;
  localparam int          IDLE_PCT   = 34;
  localparam int          STALL_MAX  = 5000;
  localparam int          DRAIN_WAIT = 100;
  localparam int          MAX_SHOWN  = 10;

  class cmd_fifo_scoreboard;
    logic [7:0]  ring [DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    bit          line_flag;
    cbf_out_t    expected_words [$];
    int          mismatches;
    int          strays;
    int          words_checked;
    int          lines_drained;
    int          drops;

    function new();
      foreach (ring[i]) ring[i] = 8'h00;
      wr_ptr = 0;
      rd_ptr = 0;
      line_flag = 1'b0;
      mismatches = 0;
      strays = 0;
      words_checked = 0;
      lines_drained = 0;
      drops = 0;
    endfunction

    function bit ring_empty();
      return wr_ptr == rd_ptr;
    endfunction

    function bit ring_full();
      return ((wr_ptr + 1) % DEPTH) == rd_ptr;
    endfunction

    function void add_expected(logic [7:0] data, status_e st, logic fin);
      cbf_out_t r;
      r.data_out        = data;
      r.status          = st;
      r.last            = fin;
      r.is_empty        = ring_empty();
      r.is_full         = ring_full();
      r.command_pending = line_flag;
      expected_words.push_back(r);
    endfunction

    function void note_word(cbf_in_t w);
      logic [7:0] held;
      bit         have;
      held = 8'h00;
      have = 1'b0;
      case (w.cmd)
        CMD_PUT: begin
          if (ring_full()) begin
            drops++;
            add_expected(8'h00, ST_FULL, 1'b1);
          end else begin
            ring[wr_ptr] = w.byte_in;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (w.byte_in == LINE_END) line_flag = 1'b1;
            add_expected(8'h00, ST_OK, 1'b1);
          end
        end
        CMD_GET: begin
          if (ring_empty()) begin
            add_expected(8'h00, ST_EMPTY, 1'b1);
          end else begin
            held = ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            add_expected(held, ST_OK, 1'b1);
          end
        end
        default: begin
          if (w.cmd != CMD_LINE || !line_flag) begin
            add_expected(8'h00, ST_NOCMD, 1'b1);
          end else begin
            lines_drained++;
            // each drained byte is reported one pop late, with the state after the next pop
            while (!ring_empty() && ring[rd_ptr] != LINE_END) begin
              if (have) begin
                rd_ptr = (rd_ptr + 1) % DEPTH;
                add_expected(held, ST_OK, 1'b0);
                held = ring[(rd_ptr + DEPTH - 1) % DEPTH];
              end else begin
                held = ring[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
              end
              have = 1'b1;
            end
            if (!ring_empty()) rd_ptr = (rd_ptr + 1) % DEPTH;
            line_flag = 1'b0;
            if (have) add_expected(held, ST_OK, 1'b1);
            else add_expected(8'h00, ST_EMPTYCMD, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_word(cbf_out_t got);
      cbf_out_t exp;
      words_checked++;
      if (expected_words.size() == 0) begin
        strays++;
        if (mismatches + strays <= MAX_SHOWN)
          $display("unexpected result word: data %02h status %0d last %0b",
                   got.data_out, got.status, got.last);
        return;
      end
      exp = expected_words.pop_front();
      if (got.data_out !== exp.data_out || got.status !== exp.status ||
          got.last !== exp.last || got.is_empty !== exp.is_empty ||
          got.is_full !== exp.is_full ||
          got.command_pending !== exp.command_pending) begin
        mismatches++;
        if (mismatches + strays <= MAX_SHOWN)
          $display("mismatch: exp data %02h st %0d last %0b emp %0b full %0b pend %0b",
                   exp.data_out, exp.status, exp.last, exp.is_empty, exp.is_full,
                   exp.command_pending,
                   "\n          got data %02h st %0d last %0b emp %0b full %0b pend %0b",
                   got.data_out, got.status, got.last, got.is_empty, got.is_full,
                   got.command_pending);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  cbf_in_t  cmd_word_i;
  cbf_out_t res_word_o;

  cmd_fifo_scoreboard sb = new();
  int items_sent  = 0;
  int stall_count = 0;
  bit no_idle     = 1'b0;

  command_byte_fifo_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .cmd_word_i (cmd_word_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .res_word_o (res_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_count <= 0;
    end else begin
      if (push && !full) sb.note_word(cmd_word_i);
      if (pop && !empty) sb.check_word(res_word_o);
      if ((push && !full) || (pop && !empty)) stall_count <= 0;
      else stall_count <= stall_count + 1;
    end
  end

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (stall_count < STALL_MAX) @(posedge clk_i);
    $display("watchdog: no word moved for %0d cycles", STALL_MAX);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_word(input logic [1:0] c, input logic [7:0] b);
    cbf_in_t w;
    w.cmd     = c;
    w.byte_in = b;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    cmd_word_i <= w;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == LINE_END) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic send_line(input int len, input bit take);
    for (int i = 0; i < len; i++) send_word(CMD_PUT, text_byte());
    send_word(CMD_PUT, LINE_END);
    if (take) send_word(CMD_LINE, 8'($urandom_range(255)));
  endtask

  initial begin
    int pick;
    int n;
    rst_ni     = 1'b0;
    push       = 1'b0;
    cmd_word_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty buffer, no line, unused selector, then two bytes put and got back
    send_word(CMD_GET, 8'h00);
    send_word(CMD_LINE, 8'h00);
    send_word(CMD_NONE, 8'h00);
    send_word(CMD_PUT, 8'h00);
    send_word(CMD_PUT, 8'hff);
    send_word(CMD_GET, 8'hff);
    send_word(CMD_GET, 8'h00);
    // two-byte line
    send_word(CMD_PUT, 8'h41);
    send_word(CMD_PUT, 8'h42);
    send_word(CMD_PUT, LINE_END);
    send_word(CMD_LINE, 8'h00);
    // bare terminator gives an empty command
    send_word(CMD_PUT, LINE_END);
    send_word(CMD_LINE, 8'hff);
    // terminator taken by a get, drain runs the buffer dry
    send_word(CMD_PUT, LINE_END);
    send_word(CMD_PUT, 8'h55);
    send_word(CMD_GET, 8'h00);
    send_word(CMD_LINE, 8'h00);
    // flag still set with nothing left
    send_word(CMD_PUT, 8'h5a);
    send_word(CMD_PUT, LINE_END);
    send_word(CMD_GET, 8'h00);
    send_word(CMD_GET, 8'h00);
    send_word(CMD_LINE, 8'h00);
    send_word(CMD_NONE, 8'hff);

    while (items_sent < N_DIRECTED + N_RANDOM) begin
      no_idle = (items_sent >= 200 && items_sent < 330);
      pick = $urandom_range(99);
      if (pick < 45) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(8);
        send_line(n, $urandom_range(9) != 0);
      end else if (pick < 53) begin
        // put DEPTH-4 to DEPTH+3 bytes, near or past the limit, then up to DEPTH+2 gets
        n = $urandom_range(DEPTH + 3, DEPTH - 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(15) == 0) send_word(CMD_PUT, LINE_END);
          else send_word(CMD_PUT, text_byte());
        end
        if ($urandom_range(1)) send_word(CMD_LINE, 8'($urandom_range(255)));
        n = $urandom_range(DEPTH + 2);
        for (int i = 0; i < n; i++) send_word(CMD_GET, 8'($urandom_range(255)));
      end else if (pick < 68) begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) send_word(CMD_GET, 8'($urandom_range(255)));
      end else begin
        send_word(2'($urandom_range(3)),
                  ($urandom_range(7) == 0) ? LINE_END : 8'($urandom_range(255)));
      end
    end
    no_idle = 1'b0;
    push <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d command words, checked %0d result words", items_sent,
             sb.words_checked);
    $display("drained %0d command lines, %0d bytes dropped on a full buffer",
             sb.lines_drained, sb.drops);
    if (sb.mismatches == 0 && sb.strays == 0 && sb.expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", sb.mismatches, sb.strays,
               sb.expected_words.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> command_byte_fifo_unit.f
src/cbf_pkg.sv
src/cbf_ram.sv
src/cbf_fifo.sv
src/cbf_front.sv
src/cbf_back.sv
src/command_byte_fifo_unit.sv
tb/command_byte_fifo_unit_test.sv
